// File: hw/rtl/cr_pkg.sv
// Shared types and codes for the Catmull-Rom path follower.
// No dependencies; imported by every module of the block.
package cr_pkg;

   // item kinds carried in req_tuser
   localparam logic [2:0] OP_LOAD    = 3'd0;
   localparam logic [2:0] OP_START   = 3'd1;
   localparam logic [2:0] OP_STOP    = 3'd2;
   localparam logic [2:0] OP_TOGGLE  = 3'd3;
   localparam logic [2:0] OP_RST_T   = 3'd4;
   localparam logic [2:0] OP_TICK    = 3'd5;

   // register indexes on the csr port
   localparam logic [2:0] REG_DURATION = 3'd0;
   localparam logic [2:0] REG_TENSION  = 3'd1;
   localparam logic [2:0] REG_NUM_PTS  = 3'd2;
   localparam logic [2:0] REG_TRIG_CNT = 3'd3;
   localparam logic [2:0] REG_TRIG_P0  = 3'd4;
   localparam logic [2:0] REG_TRIG_P1  = 3'd5;
   localparam logic [2:0] REG_TRIG_P2  = 3'd6;
   localparam logic [2:0] REG_TRIG_P3  = 3'd7;

   localparam int NUM_TRIG = 4;

   // effective configuration, already clamped
   typedef struct packed {
      logic [31:0]                 dur;      // duration, zero taken as one
      logic [15:0]                 tension;
      logic [4:0]                  n;        // points in use
      logic [2:0]                  tcnt;     // triggers in use
      logic [NUM_TRIG-1:0][6:0]    pct;
   } cr_cfg_type;

   // queue entry between front and back
   typedef struct packed {
      logic                 is_tick;
      logic [3:0]           idx;
      logic signed [23:0]   z;
      logic signed [23:0]   y;
      logic signed [23:0]   x;
      logic [31:0]          sum;
      logic [NUM_TRIG-1:0]  fired;
      logic                 still;
      logic                 ended;
   } cr_job_type;

endpackage

// File: hw/rtl/cr_front.sv
// Front end: accepts request words, keeps motion state, elapsed time and
// trigger flags, and queues point loads and tick jobs. Uses cr_pkg.
module cr_front import cr_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cr_cfg_type  cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // op
   input  logic [95:0] req_tdata,   // point_index, point_x, point_y, point_z, delta_time
   output logic        push_valid,
   input  logic        push_ready,
   output cr_job_type  push_job
);

   typedef enum logic [1:0] {F_IDLE, F_TRIG, F_PUSH} state_type;

   state_type           state_ff;
   logic [31:0]         elapsed_ff;
   logic                moving_ff;
   logic [NUM_TRIG-1:0] fired_ff;
   cr_job_type          job_ff;

   logic                accept;
   logic [3:0]          in_idx;
   logic [15:0]         in_dt;
   logic [32:0]         sum_in;
   logic [NUM_TRIG-1:0] hit;
   logic [39:0]         lhs;
   logic [39:0]         rhs;

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_idx     = req_tdata[3:0];
   assign in_dt      = req_tdata[91:76];
   assign sum_in     = {1'b0, elapsed_ff} + 33'(in_dt);
   assign push_valid = (state_ff == F_PUSH);
   assign push_job   = job_ff;

   // elapsed*100 >= percent*duration, exact
   always_comb begin
      lhs = 40'(job_ff.sum) * 40'd100;
      for (int i = 0; i < NUM_TRIG; i++) begin
         rhs    = 40'(cfg.pct[i]) * 40'(cfg.dur);
         hit[i] = (3'(i) < cfg.tcnt) && !fired_ff[i] && (lhs >= rhs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         elapsed_ff <= '0;
         moving_ff  <= 1'b0;
         fired_ff   <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  job_ff.idx   <= in_idx;
                  job_ff.x     <= $signed(req_tdata[27:4]);
                  job_ff.y     <= $signed(req_tdata[51:28]);
                  job_ff.z     <= $signed(req_tdata[75:52]);
                  job_ff.fired <= '0;
                  case (req_tuser)
                     OP_LOAD: begin
                        job_ff.is_tick <= 1'b0;
                        if (int'(in_idx) < MAX_POINTS) begin
                           state_ff <= F_PUSH;
                        end
                     end
                     OP_START: begin
                        elapsed_ff <= '0;
                        moving_ff  <= 1'b1;
                     end
                     OP_STOP:   moving_ff  <= 1'b0;
                     OP_TOGGLE: moving_ff  <= !moving_ff;
                     OP_RST_T:  elapsed_ff <= '0;
                     OP_TICK: begin
                        if (moving_ff) begin
                           job_ff.is_tick <= 1'b1;
                           if (sum_in >= {1'b0, cfg.dur}) begin
                              elapsed_ff   <= cfg.dur;
                              job_ff.sum   <= cfg.dur;
                              moving_ff    <= 1'b0;
                              job_ff.ended <= 1'b1;
                              job_ff.still <= 1'b0;
                           end else begin
                              elapsed_ff   <= sum_in[31:0];
                              job_ff.sum   <= sum_in[31:0];
                              job_ff.ended <= 1'b0;
                              job_ff.still <= 1'b1;
                           end
                           state_ff <= F_TRIG;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            F_TRIG: begin
               fired_ff     <= fired_ff | hit;
               job_ff.fired <= hit;
               state_ff     <= F_PUSH;
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// File: hw/rtl/cr_queue.sv
// Two-entry queue decoupling the front end from the evaluation back end.
// Uses cr_pkg for the entry type.
module cr_queue import cr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  cr_job_type push_job,
   output logic       pop_valid,
   input  logic       pop_ready,
   output cr_job_type pop_job
);

   cr_job_type  ent_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  cnt_ff;
   logic        do_push;
   logic        do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_job    = ent_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

// File: hw/rtl/cr_back.sv
// Back end: point memory, progress divider, segment select and the cubic
// evaluated per axis on one shared multiplier. Uses cr_pkg.
module cr_back import cr_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cr_cfg_type  cfg,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  cr_job_type  job,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata   // pos_x, pos_y, pos_z, progress, still_moving, ended,
                                   // triggers_fired
);

   localparam int AW = $clog2(MAX_POINTS);

   typedef enum logic [3:0] {
      B_IDLE, B_DIV, B_SEG, B_RD, B_COEF, B_MD, B_MU, B_MQ, B_MS, B_SAT, B_EMIT
   } state_type;

   state_type            state_ff;
   logic [71:0]          pt_mem [MAX_POINTS];
   logic [71:0]          mem_q_ff;
   logic [71:0]          p_ff [4];
   logic [32:0]          rem_ff;
   logic [16:0]          quo_ff;
   logic [4:0]           cnt_ff;
   logic [1:0]           ax_ff;
   logic [4:0]           seg_ff;
   logic [16:0]          t_ff;
   logic signed [27:0]   a_ff, b_ff, c_ff, d_ff;
   logic signed [63:0]   prod_ff;
   logic signed [23:0]   pos_ff [3];
   logic                 still_ff, ended_ff;
   logic [NUM_TRIG-1:0]  fired_ff;
   logic                 rsp_valid_ff;
   logic [95:0]          rsp_data_ff;

   logic [AW+3:0]        wr_wide;
   logic [AW+5:0]        rd_wide;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [5:0]           e, ix;
   logic [4:0]           segs;
   logic [21:0]          s;
   logic [32:0]          rem_sub;
   logic                 ge;
   logic [2:0]           cm1;
   logic signed [27:0]   p0, p1, p2, p3;
   logic signed [47:0]   mul_a;
   logic signed [17:0]   mul_b;
   logic signed [63:0]   u, h, sv, r;
   logic signed [23:0]   sat;

   assign pop_ready  = (state_ff == B_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign wr_wide = {{AW{1'b0}}, job.idx};
   assign wr_addr = wr_wide[AW-1:0];
   assign segs    = cfg.n - 5'd1;

   // extended point index: first and last points repeated
   always_comb begin
      e  = 6'(seg_ff) + 6'(cnt_ff[2:0]);
      ix = (e == 6'd0) ? 6'd0 : e - 6'd1;
      if (ix > 6'(segs)) ix = 6'(segs);
   end
   assign rd_wide = {{AW{1'b0}}, ix};
   assign rd_addr = rd_wide[AW-1:0];
   assign cm1     = cnt_ff[2:0] - 3'd1;

   assign ge      = (rem_ff >= {1'b0, cfg.dur});
   assign rem_sub = ge ? rem_ff - {1'b0, cfg.dur} : rem_ff;
   assign s       = 22'(quo_ff) * 22'(segs);

   assign p0 = 28'($signed(p_ff[0][ax_ff*24 +: 24]));
   assign p1 = 28'($signed(p_ff[1][ax_ff*24 +: 24]));
   assign p2 = 28'($signed(p_ff[2][ax_ff*24 +: 24]));
   assign p3 = 28'($signed(p_ff[3][ax_ff*24 +: 24]));

   assign u  = prod_ff + (64'(c_ff) <<< 16);
   assign h  = prod_ff + (64'(b_ff) <<< 32);
   assign sv = (prod_ff >>> 32) + 64'(a_ff);
   assign r  = prod_ff >>> 14;

   always_comb begin
      mul_b = $signed({1'b0, t_ff});
      case (state_ff)
         B_MD:    mul_a = 48'(d_ff);
         B_MU:    mul_a = u[47:0];
         B_MQ:    mul_a = h[63:16];
         B_MS: begin
            mul_a = sv[47:0];
            mul_b = $signed({2'b00, cfg.tension});
         end
         default: mul_a = '0;
      endcase
      if (r > 64'sd8388607)       sat = 24'sh7FFFFF;
      else if (r < -64'sd8388608) sat = -24'sh800000;
      else                        sat = r[23:0];
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready && !job.is_tick) begin
         pt_mem[wr_addr] <= {job.z, job.y, job.x};
      end
      mem_q_ff <= pt_mem[rd_addr];
      prod_ff  <= 64'(mul_a) * 64'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in B_EMIT the output register is reloaded whenever it drains
         if (rsp_valid_ff && rsp_tready && state_ff != B_EMIT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (pop_valid && job.is_tick) begin
                  rem_ff   <= {1'b0, job.sum};
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  still_ff <= job.still;
                  ended_ff <= job.ended;
                  fired_ff <= job.fired;
                  state_ff <= B_DIV;
               end
            end
            // one quotient bit per cycle: 1 integer bit, 16 fraction bits
            B_DIV: begin
               quo_ff <= {quo_ff[15:0], ge};
               rem_ff <= {rem_sub[31:0], 1'b0};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd16) state_ff <= B_SEG;
            end
            B_SEG: begin
               if (s[21:16] >= 6'(segs)) begin
                  seg_ff <= segs - 5'd1;
                  t_ff   <= 17'h10000;
               end else begin
                  seg_ff <= s[20:16];
                  t_ff   <= {1'b0, s[15:0]};
               end
               cnt_ff   <= '0;
               state_ff <= B_RD;
            end
            // address goes out at count k, data lands at k+1
            B_RD: begin
               if (cnt_ff != 5'd0) p_ff[cm1[1:0]] <= mem_q_ff;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd4) begin
                  ax_ff    <= '0;
                  state_ff <= B_COEF;
               end
            end
            B_COEF: begin
               a_ff     <= 28'(p1 * 2);
               b_ff     <= p2 - p0;
               c_ff     <= 28'(p0 * 2 - p1 * 5 + p2 * 4 - p3);
               d_ff     <= 28'(p1 * 3 - p0 - p2 * 3 + p3);
               state_ff <= B_MD;
            end
            B_MD:  state_ff <= B_MU;
            B_MU:  state_ff <= B_MQ;
            B_MQ:  state_ff <= B_MS;
            B_MS:  state_ff <= B_SAT;
            B_SAT: begin
               pos_ff[ax_ff] <= sat;
               if (ax_ff == 2'd2) begin
                  state_ff <= B_EMIT;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= B_COEF;
               end
            end
            B_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {1'b0, fired_ff, ended_ff, still_ff, quo_ff,
                                   pos_ff[2], pos_ff[1], pos_ff[0]};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// File: hw/rtl/catmull_rom_path_follower_core.sv
// Catmull-Rom path follower: a point moves along a spline through loaded points.
// A tick passes through the front end and queue, the divider, segment select, the point
// reads, per-axis evaluation on one shared 48x18 multiplier and the output register.
// The back end takes a new tick only once the previous result is in the output register.
// Synchronous active-high reset clears control state and registers to defaults;
// the point memory is undefined until loaded.
module catmull_rom_path_follower_core import cr_pkg::*; #(
   parameter int MAX_POINTS   = 16,
   parameter int MAX_TRIGGERS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // op
   input  logic [95:0] req_tdata,   // point_index, point_x, point_y, point_z, delta_time
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // pos_x, pos_y, pos_z, progress, still_moving, ended,
                                    // triggers_fired
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0]              duration_ff;
   logic [15:0]              tension_ff;
   logic [4:0]               num_pts_ff;
   logic [2:0]               trig_cnt_ff;
   logic [NUM_TRIG-1:0][6:0] pct_ff;
   cr_cfg_type               cfg;
   logic                     q_push, q_push_rdy, q_pop, q_pop_rdy;
   cr_job_type               q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= 32'd1000000;
         tension_ff  <= 16'd8192;
         num_pts_ff  <= 5'd2;
         trig_cnt_ff <= 3'd0;
         pct_ff      <= {NUM_TRIG{7'd100}};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DURATION: duration_ff <= csr_data;
            REG_TENSION:  tension_ff  <= csr_data[15:0];
            REG_NUM_PTS:  num_pts_ff  <= csr_data[4:0];
            REG_TRIG_CNT: trig_cnt_ff <= csr_data[2:0];
            REG_TRIG_P0:  pct_ff[0]   <= csr_data[6:0];
            REG_TRIG_P1:  pct_ff[1]   <= csr_data[6:0];
            REG_TRIG_P2:  pct_ff[2]   <= csr_data[6:0];
            REG_TRIG_P3:  pct_ff[3]   <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.dur     = (duration_ff == 32'd0) ? 32'd1 : duration_ff;
      cfg.tension = tension_ff;
      if (num_pts_ff < 5'd2)                    cfg.n = 5'd2;
      else if (int'(num_pts_ff) > MAX_POINTS)   cfg.n = 5'(MAX_POINTS);
      else                                      cfg.n = num_pts_ff;
      cfg.tcnt = (int'(trig_cnt_ff) > MAX_TRIGGERS) ? 3'(MAX_TRIGGERS) : trig_cnt_ff;
      cfg.pct  = pct_ff;
   end

   cr_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (q_push),
      .push_ready (q_push_rdy),
      .push_job   (q_in)
   );

   cr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_ready (q_push_rdy),
      .push_job   (q_in),
      .pop_valid  (q_pop),
      .pop_ready  (q_pop_rdy),
      .pop_job    (q_out)
   );

   cr_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (q_pop),
      .pop_ready  (q_pop_rdy),
      .job        (q_out),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("result valid right after reset");

   a_end_not_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[90] && rsp_tdata[89]))
      else $error("word marks both end of motion and still moving");

   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[88:72] <= 17'h10000))
      else $error("progress beyond end");

   a_end_full_progress: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[90]) |-> (rsp_tdata[88:72] == 17'h10000))
      else $error("ending word without full progress");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for catmull_rom_path_follower_core: directed table, then
// randomized phases under varying register settings, checked by an in-bench predictor or typed rows.
// Depends on cr_pkg (op codes, register indexes) and the core RTL.
module tb_top;
   import cr_pkg::*;

   localparam int LIMIT     = 600000;
   localparam int SETTLE    = 60;
   localparam int NUM_SLOTS = 16;

   // result word, lowest field last
   typedef struct packed {
      logic [3:0]         fired;
      logic               ended;
      logic               still;
      logic [16:0]        prog;
      logic signed [23:0] z;
      logic signed [23:0] y;
      logic signed [23:0] x;
   } path_rsp_type;

   typedef struct {
      logic [2:0]         op;
      logic [3:0]         idx;
      logic signed [23:0] x, y, z;
      logic [15:0]        dt;
      bit                 typed;
      path_rsp_type       rsp;
   } dir_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   catmull_rom_path_follower_core uut (.*);

   // predictor state
   logic signed [23:0] pt_x[NUM_SLOTS], pt_y[NUM_SLOTS], pt_z[NUM_SLOTS];
   logic [31:0] elapsed_r, dur_r;
   logic        moving_r;
   logic [3:0]  fired_r;
   logic [15:0] tension_r;
   logic [4:0]  npts_r;
   logic [2:0]  tcnt_r;
   logic [6:0]  pct_r[4];

   path_rsp_type pending_pos[$];
   int  errors, words_sent, results_seen, settings_used, cycles;
   bit  no_idle;
   dir_row_type dir_tab[19];

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= no_idle || ($urandom_range(99) >= 17);
   end

   function automatic longint eval_axis(longint p0, longint p1, longint p2, longint p3,
                                        longint t);
      longint a, b, c, d, h, q, s, v;
      a = 2 * p1;
      b = p2 - p0;
      c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      d = -p0 + 3 * p1 - 3 * p2 + p3;
      h = (d * t + c * 65536) * t + b * (longint'(1) << 32);
      q = h >>> 16;
      s = ((q * t) >>> 32) + a;
      v = (s * longint'(tension_r)) >>> 14;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v;
   endfunction

   function automatic bit predict_path(logic [2:0] op, logic [3:0] idx, logic signed [23:0] x,
                                       logic signed [23:0] y, logic signed [23:0] z,
                                       logic [15:0] dt, output path_rsp_type r);
      longint unsigned dur, sum, prog, s, seg, t, n, e, k_idx;
      longint px[4], py[4], pz[4];
      r = '0;
      case (op)
         OP_LOAD: begin
            pt_x[idx] = x; pt_y[idx] = y; pt_z[idx] = z;
            return 0;
         end
         OP_START: begin elapsed_r = 0; moving_r = 1; return 0; end
         OP_STOP: begin moving_r = 0; return 0; end
         OP_TOGGLE: begin moving_r = !moving_r; return 0; end
         OP_RST_T: begin elapsed_r = 0; return 0; end
         OP_TICK: ;
         default: return 0;
      endcase
      if (!moving_r) return 0;
      dur = (dur_r == 0) ? 1 : dur_r;
      sum = longint'(elapsed_r) + dt;
      if (sum >= dur) begin
         sum = dur;
         moving_r = 0;
         r.ended = 1;
      end
      elapsed_r = sum[31:0];
      prog = (sum << 16) / dur;
      for (int i = 0; i < 4; i++) begin
         if (i < tcnt_r && !fired_r[i] && sum * 100 >= longint'(pct_r[i]) * dur) begin
            fired_r[i] = 1;
            r.fired[i] = 1;
         end
      end
      n = (npts_r < 2) ? 2 : (npts_r > NUM_SLOTS) ? NUM_SLOTS : npts_r;
      s = prog * (n - 1);
      seg = s >> 16;
      t = s & 64'hFFFF;
      if (seg >= n - 1) begin
         seg = n - 2;
         t = 65536;
      end
      for (int k = 0; k < 4; k++) begin
         e = seg + k;
         k_idx = (e == 0) ? 0 : e - 1;
         if (k_idx > n - 1) k_idx = n - 1;
         px[k] = pt_x[k_idx]; py[k] = pt_y[k_idx]; pz[k] = pt_z[k_idx];
      end
      r.x = 24'(eval_axis(px[0], px[1], px[2], px[3], t));
      r.y = 24'(eval_axis(py[0], py[1], py[2], py[3], t));
      r.z = 24'(eval_axis(pz[0], pz[1], pz[2], pz[3], t));
      r.prog = prog[16:0];
      r.still = moving_r;
      return 1;
   endfunction

   always @(posedge clock) begin
      path_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[94:0];
         results_seen++;
         if (pending_pos.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", rsp_tdata);
         end else begin
            want = pending_pos.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.prog !== want.prog || got.still !== want.still ||
                got.ended !== want.ended || got.fired !== want.fired) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch: exp pos %0d %0d %0d prog %0d st %b end %b trg %h",
                           want.x, want.y, want.z, want.prog, want.still, want.ended,
                           want.fired);
                  $display("          got pos %0d %0d %0d prog %0d st %b end %b trg %h",
                           got.x, got.y, got.z, got.prog, got.still, got.ended, got.fired);
               end
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_DURATION: dur_r = val;
         REG_TENSION:  tension_r = val[15:0];
         REG_NUM_PTS:  npts_r = val[4:0];
         REG_TRIG_CNT: tcnt_r = val[2:0];
         default:      pct_r[idx - REG_TRIG_P0] = val[6:0];
      endcase
   endtask

   // typed expectation overrides the predicted one, predictor state still advances
   task automatic send_word(logic [2:0] op, logic [3:0] idx, logic signed [23:0] x,
                            logic signed [23:0] y, logic signed [23:0] z, logic [15:0] dt,
                            bit typed = 0, path_rsp_type typed_rsp = '0);
      path_rsp_type r;
      if (!no_idle && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, dt, z, y, x, idx};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (predict_path(op, idx, x, y, z, dt, r)) pending_pos.push_back(typed ? typed_rsp : r);
   endtask

   task automatic drain_out();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (pending_pos.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rnd_coord();
      case ($urandom_range(9))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         default: return 24'($urandom());
      endcase
   endfunction

   initial begin
      longint unsigned lim;
      int r;
      logic [15:0] dt;
      elapsed_r = 0; moving_r = 0; fired_r = 0;
      dur_r = 1000000; tension_r = 8192; npts_r = 2; tcnt_r = 0;
      foreach (pct_r[i]) pct_r[i] = 100;
      dir_tab = '{
         '{OP_LOAD, 0, 24'sh7FFFFF, 24'sh800000, 0, 0, 0, '0},
         '{OP_LOAD, 1, 24'sh800000, 24'sh7FFFFF, 256, 0, 0, '0},
         '{OP_LOAD, 15, 123, -45, 6789, 0, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 500, 0, '0},
         '{OP_START, 0, 0, 0, 0, 0, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 0, 1,
           '{4'h0, 1'b0, 1'b1, 17'd0, 24'sd0, 24'sh800000, 24'sh7FFFFF}},
         '{OP_TICK, 0, 0, 0, 0, 300, 0, '0},
         '{OP_STOP, 0, 0, 0, 0, 0, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 10, 0, '0},
         '{OP_TOGGLE, 0, 0, 0, 0, 0, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 16'hFFFF, 1,
           '{4'h0, 1'b1, 1'b0, 17'd65536, 24'sd256, 24'sh7FFFFF, 24'sh800000}},
         '{OP_TOGGLE, 0, 0, 0, 0, 0, 0, '0},
         '{OP_RST_T, 0, 0, 0, 0, 0, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 1, 0, '0},
         '{3'd6, 0, 0, 0, 0, 0, 0, '0},
         '{3'd7, 0, 0, 0, 0, 0, 0, '0},
         '{OP_LOAD, 1, -1000, 77, -3, 0, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 999, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 0, 0, '0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_DURATION, 1000);
      csr_valid <= 1'b0;
      foreach (dir_tab[i])
         send_word(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                   dir_tab[i].dt, dir_tab[i].typed, dir_tab[i].rsp);
      drain_out();

      // every slot loaded before point counts above two are used
      for (int i = 0; i < NUM_SLOTS; i++)
         send_word(OP_LOAD, 4'(i), rnd_coord(), rnd_coord(), rnd_coord(), 0);
      drain_out();

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: write_reg(REG_DURATION, 1);
            1: write_reg(REG_DURATION, 0);
            2: write_reg(REG_DURATION, 32'hFFFFFFFF);
            default: write_reg(REG_DURATION, $urandom_range(300, 400000));
         endcase
         write_reg(REG_TENSION, p == 3 ? 0 : p == 4 ? 16'hFFFF : $urandom_range(0, 20000));
         write_reg(REG_NUM_PTS, p == 5 ? 16 : p == 6 ? 0 : p == 7 ? 31 : $urandom_range(2, 16));
         write_reg(REG_TRIG_CNT, p == 8 ? 7 : $urandom_range(0, 7));
         for (int i = 0; i < 4; i++)
            write_reg(3'(REG_TRIG_P0 + i), $urandom_range(3) == 0 ? 100 * $urandom_range(1)
                                                                 : $urandom_range(0, 127));
         csr_valid <= 1'b0;
         settings_used++;
         no_idle = (p == 5 || p == 6);
         lim = (dur_r / 6) + 1;
         if (lim > 65535) lim = 65535;
         repeat (52) begin
            r = $urandom_range(99);
            if (!moving_r && $urandom_range(99) < 60) send_word(OP_START, 0, 0, 0, 0, 0);
            case ($urandom_range(9))
               0: dt = 0;
               1: dt = 16'hFFFF;
               default: dt = 16'($urandom_range(0, lim));
            endcase
            if (r < 60) send_word(OP_TICK, 0, 0, 0, 0, dt);
            else if (r < 66) send_word(OP_START, 0, 0, 0, 0, 0);
            else if (r < 71) send_word(OP_STOP, 0, 0, 0, 0, 0);
            else if (r < 76) send_word(OP_TOGGLE, 0, 0, 0, 0, 0);
            else if (r < 81) send_word(OP_RST_T, 0, 0, 0, 0, 0);
            else if (r < 95)
               send_word(OP_LOAD, 4'($urandom_range(15)), rnd_coord(), rnd_coord(),
                         rnd_coord(), 0);
            else send_word(3'($urandom_range(6, 7)), 4'($urandom()), 24'($urandom()),
                           24'($urandom()), 24'($urandom()), 16'($urandom()));
         end
         drain_out();
         no_idle = 0;
      end

      $display("sent %0d words over %0d register settings, checked %0d results, %0d mismatches",
               words_sent, settings_used + 1, results_seen, errors);
      if (errors == 0 && pending_pos.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: catmull_rom_path_follower_core.f
hw/rtl/cr_pkg.sv
hw/rtl/cr_front.sv
hw/rtl/cr_queue.sv
hw/rtl/cr_back.sv
hw/rtl/catmull_rom_path_follower_core.sv
test/tb_top.sv
